[rtl/core/dxtd_pkg.sv]
// Shared types, constants and helpers of the DXT block texel decoder.
`default_nettype none
package dxtd_pkg;

  localparam int unsigned NumTexels = 16;
  localparam int unsigned CntW      = $clog2(NumTexels);
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [1:0] FmtDxt1   = 2'd0;
  localparam logic [1:0] FmtDxt1Be = 2'd1;
  localparam logic [1:0] FmtDxt3   = 2'd2;
  localparam logic [1:0] FmtDxt5   = 2'd3;

  localparam logic RegBlockFormat = 1'b0;

  localparam logic [9:0]  Recip3      = 10'd683;
  localparam int unsigned Recip3Shift = 11;
  localparam logic [11:0] Recip5      = 12'd3277;
  localparam logic [11:0] Recip7      = 12'd2341;
  localparam int unsigned Recip57Shift = 14;

  localparam logic [7:0] AlphaOpaque = 8'hFF;
  localparam logic [7:0] AlphaClear  = 8'h00;

  typedef struct packed {
    logic [63:0] color_block;
    logic [63:0] alpha_block;
  } block_t;

  typedef struct packed {
    logic [3:0] texel_index;
    logic [7:0] alpha_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_texel;
  } texel_t;

  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [1:0]      fmt;
    logic [31:0]     idx;
    logic [63:0]     alpha_block;
    logic [3:0][2:0][7:0] pal;
    logic [7:0]      pal3_alpha;
    logic [7:0][7:0] alpha_tab;
  } act_t;

  function automatic rgb_t widen565(input logic [15:0] c);
    rgb_t rgb;
    rgb[0] = {c[15:11], c[15:13]};
    rgb[1] = {c[10:5], c[10:9]};
    rgb[2] = {c[4:0], c[4:2]};
    return rgb;
  endfunction

endpackage
`default_nettype wire

[rtl/core/dxt_block_texel_decoder.sv]
// Top level of the DXT block texel decoder: ports, register, lanes and sequencer.
//
//   channel   | ports                              | handshake
//   ----------+------------------------------------+-----------------------------
//   block in  | start, busy, in_word_i             | taken when start & !busy
//   texel out | texel_valid_o, texel_o             | one-cycle strobe, no back-off
//   config    | psel, penable, pwrite, paddr, ...  | APB, pready always high
//
// One block yields sixteen texels, one per cycle, counted by the texel sequencer.
// A taken block passes the input register, the active register and the merge
// register before its first texel appears. A block waits in the input register
// while the previous one drains, so blocks follow back to back without gaps.
// Reset sets the format to DXT1 and drops any block in flight.
// The receiver cannot stall; busy is high only while the input register is full.
`default_nettype none
module dxt_block_texel_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire dxtd_pkg::block_t              in_word_i,
  output logic                               texel_valid_o,
  output dxtd_pkg::texel_t                   texel_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dxtd_pkg::PaddrW-1:0]   paddr,
  input  wire logic [dxtd_pkg::ApbDataW-1:0] pwdata,
  output logic [dxtd_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready
);

  localparam logic [dxtd_pkg::CntW-1:0] CntLast = dxtd_pkg::CntW'(dxtd_pkg::NumTexels - 1);

  logic [1:0]                fmt_q;
  logic                      blk_valid_q;
  dxtd_pkg::block_t          blk_q;
  logic                      act_valid_q;
  logic [dxtd_pkg::CntW-1:0] cnt_q;
  dxtd_pkg::act_t            act_q;
  dxtd_pkg::act_t            act_d;
  logic                      accept;
  logic                      load;
  logic                      cfg_wr;
  logic [15:0]               c0;
  logic [15:0]               c1;
  logic                      gt;
  dxtd_pkg::rgb_t            e0;
  dxtd_pkg::rgb_t            e1;
  logic [2:0][7:0]           p2;
  logic [2:0][7:0]           p3;
  logic [7:0][7:0]           alpha_tab;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == dxtd_pkg::RegBlockFormat) ? dxtd_pkg::ApbDataW'(fmt_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= dxtd_pkg::FmtDxt1;
    end else if (cfg_wr && paddr[2] == dxtd_pkg::RegBlockFormat) begin
      fmt_q <= pwdata[1:0];
    end
  end

  // input register and sequencer control
  assign busy   = blk_valid_q;
  assign accept = start && !busy;
  assign load   = blk_valid_q && (!act_valid_q || cnt_q == CntLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
      act_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (accept) begin
        blk_valid_q <= 1'b1;
      end else if (load) begin
        blk_valid_q <= 1'b0;
      end
      if (load) begin
        act_valid_q <= 1'b1;
        cnt_q       <= '0;
      end else if (act_valid_q) begin
        if (cnt_q == CntLast) begin
          act_valid_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      blk_q <= in_word_i;
    end
    if (load) begin
      act_q <= act_d;
    end
  end

  // endpoints
  always_comb begin
    if (fmt_q == dxtd_pkg::FmtDxt1Be) begin
      c0 = {blk_q.color_block[7:0], blk_q.color_block[15:8]};
      c1 = {blk_q.color_block[23:16], blk_q.color_block[31:24]};
    end else begin
      c0 = blk_q.color_block[15:0];
      c1 = blk_q.color_block[31:16];
    end
  end

  assign gt = c0 > c1;
  assign e0 = dxtd_pkg::widen565(c0);
  assign e1 = dxtd_pkg::widen565(c1);

  for (genvar ch = 0; ch < 3; ch++) begin : g_color
    dxtd_color_lane u_lane (
      .e0_i (e0[ch]),
      .e1_i (e1[ch]),
      .gt_i (gt),
      .p2_o (p2[ch]),
      .p3_o (p3[ch])
    );
  end

  for (genvar k = 0; k < 8; k++) begin : g_alpha
    dxtd_alpha_lane u_lane (
      .code_i  (3'(k)),
      .a0_i    (blk_q.alpha_block[7:0]),
      .a1_i    (blk_q.alpha_block[15:8]),
      .alpha_o (alpha_tab[k])
    );
  end

  always_comb begin
    act_d.fmt         = fmt_q;
    act_d.idx         = blk_q.color_block[63:32];
    act_d.alpha_block = blk_q.alpha_block;
    act_d.pal[0]      = e0;
    act_d.pal[1]      = e1;
    act_d.pal[2]      = p2;
    act_d.pal[3]      = p3;
    act_d.pal3_alpha  = (fmt_q == dxtd_pkg::FmtDxt1Be && !gt) ?
                        dxtd_pkg::AlphaClear : dxtd_pkg::AlphaOpaque;
    act_d.alpha_tab   = alpha_tab;
  end

  dxtd_texel_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (act_valid_q),
    .cnt_i         (cnt_q),
    .act_i         (act_q),
    .texel_valid_o (texel_valid_o),
    .texel_o       (texel_o)
  );

  a_accept_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted block not held");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    texel_valid_o && texel_o.last_texel |-> texel_o.texel_index == CntLast)
    else $error("last texel flag off the final position");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    texel_valid_o && texel_o.texel_index != '0 |->
      $past(texel_valid_o) && texel_o.texel_index == $past(texel_o.texel_index) + 1'b1)
    else $error("texel sequence broken");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid_q && !load |=> blk_valid_q)
    else $error("waiting block lost");

endmodule
`default_nettype wire

[rtl/core/dxtd_color_lane.sv]
// One colour channel lane: builds the third and fourth palette entries.
`default_nettype none
module dxtd_color_lane (
  input  wire logic [7:0] e0_i,
  input  wire logic [7:0] e1_i,
  input  wire logic       gt_i,
  output logic      [7:0] p2_o,
  output logic      [7:0] p3_o
);

  logic [9:0]  sum2;
  logic [9:0]  sum3;
  logic [8:0]  mid;
  logic [19:0] prod2;
  logic [19:0] prod3;

  assign sum2  = 10'({e0_i, 1'b0}) + 10'(e1_i);
  assign sum3  = 10'({e1_i, 1'b0}) + 10'(e0_i);
  assign mid   = 9'(e0_i) + 9'(e1_i);
  assign prod2 = 20'(sum2) * 20'(dxtd_pkg::Recip3);
  assign prod3 = 20'(sum3) * 20'(dxtd_pkg::Recip3);

  always_comb begin
    if (gt_i) begin
      p2_o = prod2[dxtd_pkg::Recip3Shift +: 8];
      p3_o = prod3[dxtd_pkg::Recip3Shift +: 8];
    end else begin
      p2_o = mid[8:1];
      p3_o = 8'd0;
    end
  end

endmodule
`default_nettype wire

[rtl/core/dxtd_alpha_lane.sv]
// One interpolated alpha lane: the alpha value of a single 3-bit code.
`default_nettype none
module dxtd_alpha_lane (
  input  wire logic [2:0] code_i,
  input  wire logic [7:0] a0_i,
  input  wire logic [7:0] a1_i,
  output logic      [7:0] alpha_o
);

  logic        gt;
  logic [3:0]  w0;
  logic [3:0]  w1;
  logic [11:0] sum;
  logic [23:0] prod;
  logic [7:0]  q;

  assign gt   = a0_i > a1_i;
  assign w0   = gt ? 4'(4'd8 - {1'b0, code_i}) : 4'(4'd6 - {1'b0, code_i});
  assign w1   = 4'({1'b0, code_i} - 4'd1);
  assign sum  = 12'(12'(w0) * 12'(a0_i)) + 12'(12'(w1) * 12'(a1_i));
  assign prod = 24'(sum) * 24'(gt ? dxtd_pkg::Recip7 : dxtd_pkg::Recip5);
  assign q    = prod[dxtd_pkg::Recip57Shift +: 8];

  always_comb begin
    priority if (code_i == 3'd0) begin
      alpha_o = a0_i;
    end else if (code_i == 3'd1) begin
      alpha_o = a1_i;
    end else if (!gt && code_i == 3'd6) begin
      alpha_o = dxtd_pkg::AlphaClear;
    end else if (!gt && code_i == 3'd7) begin
      alpha_o = dxtd_pkg::AlphaOpaque;
    end else begin
      alpha_o = q;
    end
  end

endmodule
`default_nettype wire

[rtl/core/dxtd_texel_merge.sv]
// Merge stage: picks palette colour and alpha of one texel and registers it.
`default_nettype none
module dxtd_texel_merge (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic [dxtd_pkg::CntW-1:0] cnt_i,
  input  wire dxtd_pkg::act_t            act_i,
  output logic                           texel_valid_o,
  output dxtd_pkg::texel_t               texel_o
);

  logic [dxtd_pkg::CntW-1:0] slot;
  logic [1:0]                sel;
  logic [3:0]                nib;
  logic [5:0]                code_off;
  logic [2:0]                code;
  logic [7:0]                alpha;
  logic                      valid_q;
  dxtd_pkg::texel_t          texel_d;
  dxtd_pkg::texel_t          texel_q;

  assign slot     = (act_i.fmt == dxtd_pkg::FmtDxt1Be) ? (cnt_i ^ 4'd3) : cnt_i;
  assign sel      = act_i.idx[{slot, 1'b0} +: 2];
  assign nib      = act_i.alpha_block[{slot, 2'b00} +: 4];
  assign code_off = 6'(6'd16 + 6'({slot, 1'b0}) + 6'(slot));
  assign code     = act_i.alpha_block[code_off +: 3];

  always_comb begin
    unique case (act_i.fmt)
      dxtd_pkg::FmtDxt3: begin
        alpha = {nib, nib};
      end
      dxtd_pkg::FmtDxt5: begin
        alpha = act_i.alpha_tab[code];
      end
      default: begin
        alpha = (sel == 2'd3) ? act_i.pal3_alpha : dxtd_pkg::AlphaOpaque;
      end
    endcase
  end

  always_comb begin
    texel_d.texel_index = cnt_i;
    texel_d.alpha_out   = alpha;
    texel_d.red_out     = act_i.pal[sel][0];
    texel_d.green_out   = act_i.pal[sel][1];
    texel_d.blue_out    = act_i.pal[sel][2];
    texel_d.last_texel  = (cnt_i == dxtd_pkg::CntW'(dxtd_pkg::NumTexels - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      texel_q <= texel_d;
    end
  end

  assign texel_valid_o = valid_q;
  assign texel_o       = texel_q;

endmodule
`default_nettype wire
